FILE: design/pcps_pkg.sv
// Shared types and constants of the PWM clock prescaler solver.
package pcps_pkg;

  localparam int unsigned FreqW = 32;
  localparam int unsigned ResW = 17;
  localparam int unsigned ExpW = 4;
  localparam int unsigned LinDivW = 22;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ModeW = 2;

  localparam int unsigned MulAW = 32;
  localparam int unsigned MulBW = ResW;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned MulCntW = $clog2(MulBW);

  localparam int unsigned DivW = 32;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [ModeW-1:0] ModeLeft = 2'd0;

  localparam logic [StatusW-1:0] StatusOk = 2'd0;
  localparam logic [StatusW-1:0] StatusBadMode = 2'd1;
  localparam logic [StatusW-1:0] StatusZeroArg = 2'd2;

  localparam logic RegMasterClk = 1'b0;
  localparam logic [31:0] MasterClkReset = 32'd84000000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: design/pcps_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module pcps_mul import pcps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output unit_stat_t       stat_o,
  output logic [MulPW-1:0] prod_o
);

  logic [MulAW-1:0]   a_q;
  logic [MulPW-1:0]   prod_q;
  logic [MulPW-1:0]   prod_d;
  logic [MulAW:0]     sum;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  always_comb begin
    sum = {1'b0, prod_q[MulPW-1:MulBW]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {sum, prod_q[MulBW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MulCntW'(MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      prod_q <= {{MulAW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o = prod_q;

endmodule

FILE: design/pcps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pcps_div import pcps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output unit_stat_t      stat_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW-1:0]    dvs_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DivW:0]      shifted;
  logic [DivW:0]      diff;
  logic               fits;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    diff = shifted - {1'b0, dvs_q};
    fits = !diff[DivW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/pwm_clock_prescaler_solver.sv
// Top level of the PWM clock prescaler solver: control sequencer, APB register, stream ports.
//
//   Channel  Direction  Content
//   s_axis   in         tuser: mode; tdata: wanted_frequency, resolution
//   m_axis   out        tuser: status; tdata: exponent, divider, too-wide flag, frequency
//   APB      in/out     register 0: master clock in hertz
//
// A rejected request goes straight to the done state and waits there for a free output slot.
// A request whose clock exceeds the master clock takes divider 1 and goes from the first
// multiplication straight to the second division, of the master clock by the resolution.
// Any other request: multiply, divide, normalise, multiply and divide, serially in that order.
// One request is worked on at a time; a new one is taken while the last result waits.
// Reset is asynchronous and loads the master clock register with 84000000.
module pwm_clock_prescaler_solver import pcps_pkg::*; #(
  parameter int unsigned MAX_PRESCALE_STEPS = 10,
  parameter int unsigned DIVIDER_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // wanted_frequency[31:0], resolution[48:32], zeros
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // exponent[3:0], divider[25:4], too wide[26],
                                     // actual_frequency[58:27], zeros
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_DIV1,
    S_NORM,
    S_MUL2,
    S_DIV2,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [31:0]          master_q;
  logic [ResW-1:0]      res_q;
  logic [StatusW-1:0]   st_q;
  logic [ExpW-1:0]      ex_q;
  logic [DivW-1:0]      div_q;
  logic                 wide_q;
  logic [FreqW-1:0]     act_q;

  logic                 out_valid_q;
  logic [StatusW-1:0]   out_status_q;
  logic [ExpW-1:0]      out_exp_q;
  logic [LinDivW-1:0]   out_div_q;
  logic                 out_wide_q;
  logic [FreqW-1:0]     out_freq_q;

  logic                 mul_start_q;
  logic [MulAW-1:0]     mul_a_q;
  logic                 div_start_q;
  logic [DivW-1:0]      div_num_q;
  logic [DivW-1:0]      div_den_q;
  unit_stat_t           mul_stat;
  unit_stat_t           div_stat;
  logic [MulPW-1:0]     mul_prod;
  logic [DivW-1:0]      div_quo;

  logic                 in_xfer;
  logic                 div_wide;
  logic                 cfg_write;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign div_wide = |div_q[DivW-1:DIVIDER_BITS];
  assign cfg_write = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMasterClk) ? master_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= MasterClkReset;
    end else if (cfg_write && (paddr[2] == RegMasterClk)) begin
      master_q <= pwdata;
    end
  end

  pcps_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (res_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  pcps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_num_q),
    .divisor_i  (div_den_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      st_q <= StatusOk;
      ex_q <= '0;
      wide_q <= 1'b0;
      out_status_q <= StatusOk;
      out_exp_q <= '0;
      out_wide_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            res_q <= s_axis_tdata[FreqW+ResW-1:FreqW];
            ex_q <= '0;
            div_q <= '0;
            wide_q <= 1'b0;
            act_q <= '0;
            if (s_axis_tuser != ModeLeft) begin
              st_q <= StatusBadMode;
              state_q <= S_DONE;
            end else if ((s_axis_tdata[FreqW-1:0] == '0) ||
                         (s_axis_tdata[FreqW+ResW-1:FreqW] == '0)) begin
              st_q <= StatusZeroArg;
              state_q <= S_DONE;
            end else begin
              st_q <= StatusOk;
              mul_a_q <= s_axis_tdata[FreqW-1:0];
              mul_start_q <= 1'b1;
              state_q <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (mul_stat.done) begin
            div_num_q <= master_q;
            div_start_q <= 1'b1;
            if (mul_prod > {{(MulPW-32){1'b0}}, master_q}) begin
              div_q <= DivW'(1);
              div_den_q <= {{(DivW-ResW){1'b0}}, res_q};
              state_q <= S_DIV2;
            end else begin
              div_den_q <= mul_prod[DivW-1:0];
              state_q <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_stat.done) begin
            div_q <= div_quo;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if ((ex_q < ExpW'(MAX_PRESCALE_STEPS)) && div_wide) begin
            div_q <= div_q >> 1;
            ex_q <= ex_q + 1'b1;
          end else begin
            wide_q <= div_wide;
            mul_a_q <= div_q << ex_q;
            mul_start_q <= 1'b1;
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_stat.done) begin
            div_num_q <= master_q;
            div_den_q <= mul_prod[DivW-1:0];
            div_start_q <= 1'b1;
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_stat.done) begin
            act_q <= div_quo;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_status_q <= st_q;
            out_exp_q <= ex_q;
            out_div_q <= div_q[LinDivW-1:0];
            out_wide_q <= wide_q;
            out_freq_q <= act_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_status_q;
  assign m_axis_tdata = {5'b0, out_freq_q, out_wide_q, out_div_q, out_exp_q};

  a_mul_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_stat.busy)
    else $error("divider started while busy");

  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != StatusOk)) |-> (m_axis_tdata == '0))
    else $error("error result carries nonzero fields");

  a_ok_divider_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatusOk)) |-> (m_axis_tdata[25:4] != '0))
    else $error("accepted request gave a zero divider");

endmodule
